// File: hw/rtl/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg: shared types and constants for the RGB to L*a*b* pixel core
// Fixed-point formats, thresholds and cube-root pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package rcl_pkg;

  localparam int unsigned PIX_W  = 8;   // one color component
  localparam int unsigned SUM_W  = 18;  // weighted component sum, up to 255255
  localparam int unsigned T_W    = 17;  // normalized value, Q0.16, 0..65536
  localparam int unsigned F_W    = 21;  // f(t), Q0.20

  localparam int unsigned DIV_XZ = 255000;  // white point sum for X and Z
  localparam int unsigned DIV_Y  = 255255;  // white point sum for Y

  localparam logic [T_W-1:0] THRESH_Q16     = 17'd580;
  localparam logic [F_W-1:0] LIN_OFFSET_Q20 = 21'd144631;

  // One radicand digit (3 bits) per cube-root stage: 63-bit radicand.
  localparam int unsigned CBRT_DIGITS = 21;

  typedef logic [T_W-1:0] t_q16_t;
  typedef logic [F_W-1:0] f_q20_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcl_norm.sv
// ----------------------------------------------------------------------------
// rcl_norm: rounded normalization by a constant white point sum
// t = round(65536 * sum / DIV) by reciprocal multiply plus one correction.
// ----------------------------------------------------------------------------
`default_nettype none
module rcl_norm #(
  parameter int unsigned DIV = rcl_pkg::DIV_XZ  // must lie in 2^17 .. 2^18-1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire  [rcl_pkg::SUM_W-1:0]  sum,
  output logic                       out_valid,
  output rcl_pkg::t_q16_t            t
);
  import rcl_pkg::*;

  localparam int unsigned    NUM_W = SUM_W + 16;
  localparam int unsigned    SHIFT = 35;
  localparam logic [17:0]    RECIP = 18'((64'd1 << SHIFT) / 64'(DIV));
  localparam logic [NUM_W-1:0] HALF = NUM_W'(DIV / 2);
  localparam logic [NUM_W-1:0] DIVN = NUM_W'(DIV);

  logic             v1, v2, v3;
  logic [NUM_W-1:0] num1, num2, num3;
  logic [T_W-1:0]   qe2, qe3;
  logic [NUM_W-1:0] pd3;
  logic [NUM_W+17:0] recip_prod;
  logic [NUM_W+T_W:0] div_prod;
  logic [NUM_W-1:0] rem3;

  assign recip_prod = (NUM_W+18)'(num1) * (NUM_W+18)'(RECIP);
  assign div_prod   = (NUM_W+T_W+1)'(qe2) * (NUM_W+T_W+1)'(DIV);
  assign rem3       = num3 - pd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    num1 <= {sum, 16'd0} + HALF;
    num2 <= num1;
    qe2  <= recip_prod[SHIFT+T_W-1:SHIFT];   // floor or floor-1
    num3 <= num2;
    qe3  <= qe2;
    pd3  <= div_prod[NUM_W-1:0];
    t    <= (rem3 >= DIVN) ? qe3 + 1'b1 : qe3;
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcl_ffunc.sv
// ----------------------------------------------------------------------------
// rcl_ffunc: f(t) in Q0.20
// Digit-by-digit cube root, one radicand digit per stage, with the
// linear branch computed alongside and chosen at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module rcl_ffunc (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  rcl_pkg::t_q16_t  t,
  output logic             out_valid,
  output rcl_pkg::f_q20_t  f
);
  import rcl_pkg::*;

  localparam int unsigned ND    = CBRT_DIGITS;
  localparam int unsigned RAD_W = 3 * ND;
  localparam int unsigned Y_W   = F_W;
  localparam int unsigned YS_W  = 2 * Y_W;
  localparam int unsigned R_W   = YS_W + 4;
  localparam int unsigned LN_W  = 27;
  localparam logic [27:0] LIN_RECIP = 28'd137438954;  // ceil(2^37 / 1000)

  logic             vld [0:ND];
  logic [T_W-1:0]   tq  [0:ND];
  logic [Y_W-1:0]   yq  [0:ND];
  logic [YS_W-1:0]  ysq [0:ND];
  logic [R_W-1:0]   rem [0:ND];
  logic [LN_W-1:0]  lin [1:ND];

  assign vld[0] = in_valid;
  assign tq[0]  = t;
  assign yq[0]  = '0;
  assign ysq[0] = '0;
  assign rem[0] = '0;

  for (genvar s = 0; s < ND; s++) begin : g_stage
    localparam int unsigned DI = ND - 1 - s;
    logic [RAD_W-1:0] rad;
    logic [2:0]       dig;
    logic [R_W-1:0]   rc, trial;
    logic             take;

    always_comb begin
      rad   = {2'b00, tq[s], 44'd0};
      dig   = rad[3*DI+2 -: 3];
      rc    = {rem[s][R_W-4:0], dig};
      trial = R_W'({ysq[s], 3'b000}) + R_W'({ysq[s], 2'b00})
            + R_W'({yq[s], 2'b00}) + R_W'({yq[s], 1'b0}) + R_W'(1);
      take  = rc >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tq[s+1] <= tq[s];
      if (take) begin
        rem[s+1] <= rc - trial;
        yq[s+1]  <= {yq[s][Y_W-2:0], 1'b1};
        ysq[s+1] <= {ysq[s][YS_W-3:0], 2'b00} + YS_W'({yq[s], 2'b00}) + YS_W'(1);
      end else begin
        rem[s+1] <= rc;
        yq[s+1]  <= {yq[s][Y_W-2:0], 1'b0};
        ysq[s+1] <= {ysq[s][YS_W-3:0], 2'b00};
      end
    end

    // linear branch: n = 124592*t + 500, then floor(n / 1000) + offset
    if (s == 0) begin : g_lin_mul
      always_ff @(posedge clk) begin
        lin[1] <= LN_W'(17'd124592 * 27'(tq[0][9:0])) + LN_W'(500);
      end
    end else if (s == 1) begin : g_lin_div
      logic [LN_W+27:0] lp;
      assign lp = (LN_W+28)'(lin[1]) * (LN_W+28)'(LIN_RECIP);
      always_ff @(posedge clk) begin
        lin[2] <= LN_W'(lp[LN_W+27:37]) + LN_W'(LIN_OFFSET_Q20);
      end
    end else begin : g_lin_pass
      always_ff @(posedge clk) begin
        lin[s+1] <= lin[s];
      end
    end
  end

  // round to nearest: bump when (2y+1)^3 <= 8 * radicand
  logic [R_W+2:0] rnd_lhs, rnd_rhs;
  logic           up;
  assign rnd_lhs = {rem[ND], 3'b000};
  assign rnd_rhs = (R_W+3)'({ysq[ND], 3'b000}) + (R_W+3)'({ysq[ND], 2'b00})
                 + (R_W+3)'({yq[ND], 2'b00}) + (R_W+3)'({yq[ND], 1'b0}) + (R_W+3)'(1);
  assign up = rnd_lhs >= rnd_rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[ND];
    end
    f <= (tq[ND] > THRESH_Q16) ? yq[ND] + F_W'(up) : F_W'(lin[ND]);
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcl_lab.sv
// ----------------------------------------------------------------------------
// rcl_lab: L*, a*, b* from f values
// Two stages: scaling products, then rounding, sign and branch select.
// ----------------------------------------------------------------------------
`default_nettype none
module rcl_lab (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  rcl_pkg::t_q16_t      ty,
  input  rcl_pkg::f_q20_t      fx,
  input  rcl_pkg::f_q20_t      fy,
  input  rcl_pkg::f_q20_t      fz,
  output logic                 out_valid,
  output logic [14:0]          lightness,
  output logic signed [17:0]   green_red_axis,
  output logic signed [16:0]   blue_yellow_axis
);
  import rcl_pkg::*;

  logic signed [F_W:0] da, db;
  logic [F_W-1:0]      mag_a, mag_b;
  logic [30:0]         lx;

  assign da    = $signed({1'b0, fx}) - $signed({1'b0, fy});
  assign db    = $signed({1'b0, fy}) - $signed({1'b0, fz});
  assign mag_a = da[F_W] ? F_W'(-da) : F_W'(da);
  assign mag_b = db[F_W] ? F_W'(-db) : F_W'(db);
  assign lx    = 31'(14'd9033 * 31'(ty)) + 31'd1280;

  // stage A
  logic        va, above_a, neg_a, neg_b;
  logic [35:0] lhi_a;
  logic [13:0] llo_a;
  logic [27:0] am_a;
  logic [25:0] bm_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    above_a <= ty > THRESH_Q16;
    lhi_a   <= 36'(15'd29696 * 36'(fy)) + 36'd524288;
    llo_a   <= lx[22:9];                     // floor(x / 512), then / 5 below
    neg_a   <= da[F_W];
    neg_b   <= db[F_W];
    am_a    <= 28'(7'd125 * 28'(mag_a)) + 28'd512;
    bm_a    <= 26'(5'd25 * 26'(mag_b)) + 26'd256;
  end

  // stage B
  logic [28:0] l5;
  logic [15:0] lhi_sub;
  logic [17:0] aq;
  logic [16:0] bq;

  assign l5      = 29'(llo_a) * 29'd26215;   // exact / 5 for 14-bit values
  assign lhi_sub = lhi_a[35:20] - 16'd4096;
  assign aq      = am_a[27:10];
  assign bq      = bm_a[25:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= va;
    end
    lightness        <= above_a ? lhi_sub[14:0] : 15'(l5[28:17]);
    green_red_axis   <= neg_a ? -$signed(aq) : $signed(aq);
    blue_yellow_axis <= neg_b ? -$signed(bq) : $signed(bq);
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgb_to_cielab_pixel_core.sv
// ----------------------------------------------------------------------------
// rgb_to_cielab_pixel_core: 8-bit RGB pixel to CIE L*a*b*, fixed point
// Fully pipelined converter, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; red,
//   green and blue are sampled there. busy is high only during reset, so a
//   new request may be issued every cycle.
//   Each result appears on lightness / green_red_axis / blue_yellow_axis for
//   exactly one cycle with done high, in order.
//   lightness is L* in 1/256 units; the axes are a* and b* in 1/256 units,
//   two's complement.
// Pipeline stages: input register, weighted sums, normalization by
//   reciprocal multiply, f(t) with a 21-stage digit-serial cube root plus
//   rounding, L*a*b* scaling.
// Throughput: one pixel per cycle; every stage is a plain register stage.
// Reset: synchronous, clears every valid bit; pixels in flight are dropped.
// The receiver cannot stall, so there is no back-pressure path.
// ----------------------------------------------------------------------------
`default_nettype none
module rgb_to_cielab_pixel_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [rcl_pkg::PIX_W-1:0]       red,
  input  wire  [rcl_pkg::PIX_W-1:0]       green,
  input  wire  [rcl_pkg::PIX_W-1:0]       blue,
  output logic                            done,
  output logic [14:0]                     lightness,
  output logic signed [17:0]              green_red_axis,
  output logic signed [16:0]              blue_yellow_axis
);
  import rcl_pkg::*;

  // no back-pressure: requests are refused only while in reset
  assign busy = rst;

  // stage 0: capture pixel
  logic             v0;
  logic [PIX_W-1:0] r0, g0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    r0 <= red;
    g0 <= green;
    b0 <= blue;
  end

  // stage 1: matrix rows with integer weights (per-mille)
  logic             v1;
  logic [SUM_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    sx <= SUM_W'(9'd490 * SUM_W'(r0)) + SUM_W'(9'd310 * SUM_W'(g0))
        + SUM_W'(8'd200 * SUM_W'(b0));
    sy <= SUM_W'(8'd177 * SUM_W'(r0)) + SUM_W'(10'd813 * SUM_W'(g0))
        + SUM_W'(4'd11 * SUM_W'(b0));
    sz <= SUM_W'(4'd10 * SUM_W'(g0)) + SUM_W'(10'd990 * SUM_W'(b0));
  end

  // normalization to white: X and Z by 255000, Y by 255255
  logic   nvx, nvy, nvz;
  t_q16_t tx, ty, tz;

  rcl_norm #(.DIV(DIV_XZ)) u_norm_x (
    .clk(clk), .rst(rst), .in_valid(v1), .sum(sx), .out_valid(nvx), .t(tx));
  rcl_norm #(.DIV(DIV_Y)) u_norm_y (
    .clk(clk), .rst(rst), .in_valid(v1), .sum(sy), .out_valid(nvy), .t(ty));
  rcl_norm #(.DIV(DIV_XZ)) u_norm_z (
    .clk(clk), .rst(rst), .in_valid(v1), .sum(sz), .out_valid(nvz), .t(tz));

  // f(t) per component; tY is delayed to line up with fY for L*
  logic   fvx, fvy, fvz;
  f_q20_t fx, fy, fz;

  rcl_ffunc u_f_x (
    .clk(clk), .rst(rst), .in_valid(nvx), .t(tx), .out_valid(fvx), .f(fx));
  rcl_ffunc u_f_y (
    .clk(clk), .rst(rst), .in_valid(nvy), .t(ty), .out_valid(fvy), .f(fy));
  rcl_ffunc u_f_z (
    .clk(clk), .rst(rst), .in_valid(nvz), .t(tz), .out_valid(fvz), .f(fz));

  localparam int unsigned F_LAT = CBRT_DIGITS + 1;
  t_q16_t ty_dly [0:F_LAT-1];

  always_ff @(posedge clk) begin
    ty_dly[0] <= ty;
    for (int i = 1; i < F_LAT; i++) begin
      ty_dly[i] <= ty_dly[i-1];
    end
  end

  // final scaling
  rcl_lab u_lab (
    .clk(clk), .rst(rst), .in_valid(fvx),
    .ty(ty_dly[F_LAT-1]), .fx(fx), .fy(fy), .fz(fz),
    .out_valid(done), .lightness(lightness),
    .green_red_axis(green_red_axis), .blue_yellow_axis(blue_yellow_axis));

  // checks
  a_norm_lockstep: assert property (@(posedge clk) disable iff (rst)
    (nvx == nvy) && (nvy == nvz)) else $error("normalizers out of step");

  a_f_lockstep: assert property (@(posedge clk) disable iff (rst)
    (fvx == fvy) && (fvy == fvz)) else $error("f units out of step");

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done) else $error("result right after reset");

  a_light_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (lightness <= 15'd25600)) else $error("L* out of range");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (green_red_axis <= 18'sd110592) && (green_red_axis >= -18'sd110592)
          && (blue_yellow_axis <= 17'sd44288) && (blue_yellow_axis >= -17'sd44288))
    else $error("a* or b* out of range");

endmodule
`default_nettype wire
